>>> rtl/nfa_symbol_matcher_defines.svh
// Assertion helpers used by the checker file.
`ifndef NFA_SYMBOL_MATCHER_DEFINES_SVH
`define NFA_SYMBOL_MATCHER_DEFINES_SVH

// Antecedent holds, consequent holds in the same cycle.
`define NFASM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfasm check failed");

// Antecedent holds, consequent holds in the next cycle.
`define NFASM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfasm check failed");

`endif

>>> rtl/nfasm_pkg.sv
package nfasm_pkg;

  // Default geometry
  localparam int NUM_STATES_DEF   = 16;
  localparam int SYMBOL_COUNT_DEF = 256;

  // Fixed port widths
  localparam int REG_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int MODE_W     = 2;
  localparam int STATE_IN_W = 4;
  localparam int SYMBOL_W   = 8;

  // Item modes
  localparam logic [MODE_W-1:0] MODE_ADD     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_BEGIN   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONSUME = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_SET  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_SET = 1'd1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CLOS1,
    ST_STEP,
    ST_CLOS2,
    ST_DONE
  } fsm_t;

endpackage

>>> rtl/nfa_symbol_matcher.sv
// NFA symbol matcher. Simulates a nondeterministic automaton of NUM_STATES
// states whose active set is a bit vector; the transition rows (one target
// mask per state and symbol, symbol 0 being the empty move) sit in a
// single-port-read, single-port-write RAM of NUM_STATES * SYMBOL_COUNT rows.
// Pulse start while busy is low to hand in one beat: mode 0 adds a
// transition, mode 1 begins a word (active set = empty closure of
// start_set), mode 2 consumes one symbol (closure, symbol step, closure).
// Every beat returns exactly one result beat: out_valid is high for one
// cycle with out_matched and out_active_set, and the receiver cannot stall
// it, so sample it on that cycle. After reset the block sweeps the RAM to
// zero, one row a cycle, over all NUM_STATES * SYMBOL_COUNT rows with busy
// high; configuration writes are taken meanwhile.
// Timing: one RAM row read per cycle, returned the cycle after, and the RAM
// read port sets the pace. An add walks ST_ADD_RD, ST_ADD_WR and ST_DONE
// (a read-modify-write of one row) before the block is idle again; an unused
// mode 3, or an add with a field out of range, goes straight to ST_DONE.
// In each expansion phase (a closure or the symbol step) states already in
// the set issue one read a cycle, lowest first, while a state that a
// returning row adds is issued only once the merged set is registered. A
// begin runs one closure, a consume its three phases, and ST_DONE follows.
// The result shows in the same cycle that busy falls, and a new start is
// taken in that cycle.
module nfa_symbol_matcher #(
  parameter int NUM_STATES   = nfasm_pkg::NUM_STATES_DEF,
  parameter int SYMBOL_COUNT = nfasm_pkg::SYMBOL_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [nfasm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nfasm_pkg::REG_W-1:0]         cfg_wdata,
  // command
  input  logic                                start,
  output logic                                busy,
  input  logic [nfasm_pkg::MODE_W-1:0]        in_mode,
  input  logic [nfasm_pkg::STATE_IN_W-1:0]    in_source_state,
  input  logic [nfasm_pkg::SYMBOL_W-1:0]      in_symbol,
  input  logic [nfasm_pkg::STATE_IN_W-1:0]    in_target_state,
  // result
  output logic                                out_valid,
  output logic                                out_matched,
  output logic [nfasm_pkg::REG_W-1:0]         out_active_set
);

  localparam int QW    = $clog2(NUM_STATES);
  localparam int SW    = $clog2(SYMBOL_COUNT);
  localparam int DEPTH = NUM_STATES * SYMBOL_COUNT;
  localparam int AW    = $clog2(DEPTH);
  localparam int REG_W = nfasm_pkg::REG_W;

  nfasm_pkg::fsm_t state_r, state_nxt;

  // control state
  logic [AW-1:0]         clr_cnt_r, clr_cnt_nxt;
  logic                  rd_vld_r, rd_vld_nxt;
  logic [REG_W-1:0]      start_r, start_nxt;
  logic [REG_W-1:0]      accept_r, accept_nxt;
  logic [NUM_STATES-1:0] active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;

  // working payload
  logic [AW-1:0]         add_addr_r, add_addr_nxt;
  logic [QW-1:0]         add_dst_r, add_dst_nxt;
  logic [SW-1:0]         sym_idx_r, sym_idx_nxt;
  logic                  sym_ok_r, sym_ok_nxt;
  logic [NUM_STATES-1:0] set_r, set_nxt;
  logic [NUM_STATES-1:0] acc_r, acc_nxt;
  logic [NUM_STATES-1:0] done_r, done_nxt;
  logic                  out_matched_r, out_matched_nxt;
  logic [REG_W-1:0]      out_active_r, out_active_nxt;

  // RAM port
  logic                  ram_we, ram_re;
  logic [AW-1:0]         ram_waddr, ram_raddr;
  logic [NUM_STATES-1:0] ram_wdata, ram_rdata;

  // decode of the incoming beat
  logic [7:0]            src_w, dst_w;
  logic [8:0]            sym_w;
  logic                  src_ok, dst_ok, in_sym_ok, add_ok;
  logic [QW-1:0]         in_src_idx, in_dst_idx;
  logic [SW-1:0]         in_sym_idx;

  // expansion scan
  logic [NUM_STATES-1:0] pend, low_oh, dst_oh;
  logic [QW-1:0]         low_idx;
  logic                  pend_any, phase_end;

  // masks folded to the state count
  logic [NUM_STATES+REG_W-1:0] start_wide, accept_wide, active_wide;
  logic [NUM_STATES-1:0]       start_mask, accept_mask;

  nfasm_row_ram #(
    .DEPTH (DEPTH),
    .WIDTH (NUM_STATES)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign start_wide  = {{NUM_STATES{1'b0}}, start_r};
  assign accept_wide = {{NUM_STATES{1'b0}}, accept_r};
  assign active_wide = {{REG_W{1'b0}}, active_r};
  assign start_mask  = start_wide[NUM_STATES-1:0];
  assign accept_mask = accept_wide[NUM_STATES-1:0];

  // Drop out-of-range states and symbols before they reach an address.
  assign src_w      = {4'b0, in_source_state};
  assign dst_w      = {4'b0, in_target_state};
  assign sym_w      = {1'b0, in_symbol};
  assign src_ok     = 32'(in_source_state) < NUM_STATES;
  assign dst_ok     = 32'(in_target_state) < NUM_STATES;
  assign in_sym_ok  = 32'(in_symbol) < SYMBOL_COUNT;
  assign add_ok     = src_ok && dst_ok && in_sym_ok;
  assign in_src_idx = src_ok ? src_w[QW-1:0] : '0;
  assign in_dst_idx = dst_ok ? dst_w[QW-1:0] : '0;
  assign in_sym_idx = in_sym_ok ? sym_w[SW-1:0] : '0;

  // States in the set that have not had their row read yet.
  assign pend      = set_r & ~done_r;
  assign pend_any  = |pend;
  assign low_oh    = pend & (~pend + 1'b1);
  assign phase_end = !pend_any && !rd_vld_r;
  assign dst_oh    = {{(NUM_STATES-1){1'b0}}, 1'b1} << add_dst_r;

  always_comb begin
    low_idx = '0;
    for (int i = NUM_STATES - 1; i >= 0; i--) begin
      if (pend[i]) begin
        low_idx = QW'(i);
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      nfasm_pkg::ST_CLEAR: begin
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = nfasm_pkg::ST_IDLE;
        end
      end
      nfasm_pkg::ST_IDLE: begin
        if (start) begin
          case (in_mode)
            nfasm_pkg::MODE_ADD: begin
              state_nxt = add_ok ? nfasm_pkg::ST_ADD_RD : nfasm_pkg::ST_DONE;
            end
            nfasm_pkg::MODE_BEGIN:   state_nxt = nfasm_pkg::ST_CLOS2;
            nfasm_pkg::MODE_CONSUME: state_nxt = nfasm_pkg::ST_CLOS1;
            default:                 state_nxt = nfasm_pkg::ST_DONE;
          endcase
        end
      end
      nfasm_pkg::ST_ADD_RD: state_nxt = nfasm_pkg::ST_ADD_WR;
      nfasm_pkg::ST_ADD_WR: state_nxt = nfasm_pkg::ST_DONE;
      nfasm_pkg::ST_CLOS1: begin
        if (phase_end) begin
          state_nxt = nfasm_pkg::ST_STEP;
        end
      end
      nfasm_pkg::ST_STEP: begin
        if (phase_end) begin
          state_nxt = nfasm_pkg::ST_CLOS2;
        end
      end
      nfasm_pkg::ST_CLOS2: begin
        if (phase_end) begin
          state_nxt = nfasm_pkg::ST_DONE;
        end
      end
      nfasm_pkg::ST_DONE: state_nxt = nfasm_pkg::ST_IDLE;
      default:            state_nxt = nfasm_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    clr_cnt_nxt     = clr_cnt_r;
    rd_vld_nxt      = rd_vld_r;
    start_nxt       = start_r;
    accept_nxt      = accept_r;
    active_nxt      = active_r;
    out_valid_nxt   = 1'b0;
    add_addr_nxt    = add_addr_r;
    add_dst_nxt     = add_dst_r;
    sym_idx_nxt     = sym_idx_r;
    sym_ok_nxt      = sym_ok_r;
    set_nxt         = set_r;
    acc_nxt         = acc_r;
    done_nxt        = done_r;
    out_matched_nxt = out_matched_r;
    out_active_nxt  = out_active_r;
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = '0;

    // Take register writes in any state, the clearing sweep included.
    if (cfg_we) begin
      case (cfg_index)
        nfasm_pkg::CFG_START_SET:  start_nxt  = cfg_wdata;
        nfasm_pkg::CFG_ACCEPT_SET: accept_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      nfasm_pkg::ST_CLEAR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
      end
      nfasm_pkg::ST_IDLE: begin
        if (start) begin
          add_addr_nxt = AW'(in_src_idx) * AW'(SYMBOL_COUNT) + AW'(in_sym_idx);
          add_dst_nxt  = in_dst_idx;
          sym_idx_nxt  = in_sym_idx;
          sym_ok_nxt   = in_sym_ok;
          done_nxt     = '0;
          acc_nxt      = '0;
          rd_vld_nxt   = 1'b0;
          case (in_mode)
            nfasm_pkg::MODE_BEGIN:   set_nxt = start_mask;
            nfasm_pkg::MODE_CONSUME: set_nxt = active_r;
            default: ;
          endcase
        end
      end
      nfasm_pkg::ST_ADD_RD: begin
        ram_re    = 1'b1;
        ram_raddr = add_addr_r;
      end
      nfasm_pkg::ST_ADD_WR: begin
        ram_we    = 1'b1;
        ram_waddr = add_addr_r;
        ram_wdata = ram_rdata | dst_oh;
      end
      nfasm_pkg::ST_CLOS1, nfasm_pkg::ST_STEP, nfasm_pkg::ST_CLOS2: begin
        // Issue the row of the lowest unexpanded state; merge the row
        // that came back from the read issued last cycle.
        if (pend_any) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(low_idx) * AW'(SYMBOL_COUNT) +
                      ((state_r == nfasm_pkg::ST_STEP) ? AW'(sym_idx_r) : AW'(0));
          done_nxt  = done_r | low_oh;
        end
        rd_vld_nxt = pend_any;
        if (rd_vld_r) begin
          if (state_r == nfasm_pkg::ST_STEP) begin
            acc_nxt = acc_r | (sym_ok_r ? ram_rdata : '0);
          end else begin
            set_nxt = set_r | ram_rdata;
          end
        end
        if (phase_end) begin
          done_nxt = '0;
          if (state_r == nfasm_pkg::ST_STEP) begin
            set_nxt = acc_r;
          end
          if (state_r == nfasm_pkg::ST_CLOS2) begin
            active_nxt = set_r;
          end
        end
      end
      nfasm_pkg::ST_DONE: begin
        out_valid_nxt   = 1'b1;
        out_matched_nxt = |(active_r & accept_mask);
        out_active_nxt  = active_wide[REG_W-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nfasm_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      start_r     <= '0;
      accept_r    <= '0;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      rd_vld_r    <= rd_vld_nxt;
      start_r     <= start_nxt;
      accept_r    <= accept_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    add_addr_r    <= add_addr_nxt;
    add_dst_r     <= add_dst_nxt;
    sym_idx_r     <= sym_idx_nxt;
    sym_ok_r      <= sym_ok_nxt;
    set_r         <= set_nxt;
    acc_r         <= acc_nxt;
    done_r        <= done_nxt;
    out_matched_r <= out_matched_nxt;
    out_active_r  <= out_active_nxt;
  end

  assign busy           = (state_r != nfasm_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_matched    = out_matched_r;
  assign out_active_set = out_active_r;

endmodule

>>> rtl/nfasm_row_ram.sv
module nfasm_row_ram #(
  parameter int DEPTH = nfasm_pkg::NUM_STATES_DEF * nfasm_pkg::SYMBOL_COUNT_DEF,
  parameter int WIDTH = nfasm_pkg::NUM_STATES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/nfasm_checker.sv
`include "nfa_symbol_matcher_defines.svh"

module nfasm_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  // A taken command makes the block busy in the next cycle.
  `NFASM_ASSERT_NEXT(a_start_sets_busy, clk, rst_n, start && !busy, busy)

  // A result beat shows exactly when a command finishes.
  `NFASM_ASSERT_SAME(a_result_ends_work, clk, rst_n, out_valid, $fell(busy))

  // One result per command: never two beats in a row.
  `NFASM_ASSERT_NEXT(a_single_beat, clk, rst_n, out_valid, !out_valid)

endmodule

bind nfa_symbol_matcher nfasm_checker u_nfasm_checker (.*);

>>> sim/tb.sv
module tb;

  localparam int MODE_W     = nfasm_pkg::MODE_W;
  localparam int STATE_IN_W = nfasm_pkg::STATE_IN_W;
  localparam int SYMBOL_W   = nfasm_pkg::SYMBOL_W;
  localparam int REG_W      = nfasm_pkg::REG_W;
  localparam int CFG_IDX_W  = nfasm_pkg::CFG_IDX_W;

  // Mode 3 has no meaning in the block; symbol 0 labels an empty move.
  localparam logic [MODE_W-1:0]   MODE_UNUSED = 2'd3;
  localparam logic [SYMBOL_W-1:0] EMPTY_SYM   = 8'd0;

  localparam int N_STATES  = nfasm_pkg::NUM_STATES_DEF;
  localparam int N_SYMBOLS = nfasm_pkg::SYMBOL_COUNT_DEF;

  // Random part: each phase builds its automaton over its own band of symbols,
  // so the store (never cleared after reset) does not saturate into one blob.
  localparam int N_PHASES    = 8;
  localparam int PHASE_BEATS = 206;
  localparam int BAND_WIDTH  = 30;
  localparam int BAND_STRIDE = 31;

  // Wait after the last drain; longer than the longest beat.
  localparam int DRAIN_CYCLES = 100;
  // Longest quiet stretch is the RAM sweep after reset.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic             matched;
    logic [REG_W-1:0] active_set;
  } match_result_t;

  typedef struct packed {
    logic [MODE_W-1:0]     mode;
    logic [STATE_IN_W-1:0] src;
    logic [SYMBOL_W-1:0]   sym;
    logic [STATE_IN_W-1:0] dst;
    logic                  typed;
    match_result_t         result;
  } dir_row_t;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  cfg_we          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [REG_W-1:0]      cfg_wdata       = '0;
  logic                  start           = 1'b0;
  logic                  busy;
  logic [MODE_W-1:0]     in_mode         = '0;
  logic [STATE_IN_W-1:0] in_source_state = '0;
  logic [SYMBOL_W-1:0]   in_symbol       = '0;
  logic [STATE_IN_W-1:0] in_target_state = '0;
  logic                  out_valid;
  logic                  out_matched;
  logic [REG_W-1:0]      out_active_set;

  // Shadow automaton: one target mask per (state, symbol), plus the active set
  // and the two registers as last written.
  logic [REG_W-1:0] trans_rows [N_STATES][N_SYMBOLS];
  logic [REG_W-1:0] active_now;
  logic [REG_W-1:0] start_reg;
  logic [REG_W-1:0] accept_reg;

  match_result_t pending_results [$];
  int            fail_count   = 0;
  int            quiet_cycles = 0;

  // Directed table, run with start_set = state 0 and accept_set = state 15.
  // Rows marked typed carry a result obvious by inspection; the rest go
  // through the shadow automaton.
  dir_row_t directed_rows [21] = '{
    // begin before any transition exists: just the start set
    '{nfasm_pkg::MODE_BEGIN,   4'd0,  8'h00, 4'd0,  1'b1, '{1'b0, 16'h0001}},
    // unused mode with every field at its top: nothing moves
    '{MODE_UNUSED,             4'd15, 8'hFF, 4'd15, 1'b1, '{1'b0, 16'h0001}},
    // adds report the active set unchanged
    '{nfasm_pkg::MODE_ADD,     4'd0,  8'h00, 4'd1,  1'b1, '{1'b0, 16'h0001}},
    '{nfasm_pkg::MODE_ADD,     4'd1,  8'hFF, 4'd15, 1'b1, '{1'b0, 16'h0001}},
    '{nfasm_pkg::MODE_ADD,     4'd15, 8'h00, 4'd14, 1'b1, '{1'b0, 16'h0001}},
    // empty-move cycle between 14 and 15
    '{nfasm_pkg::MODE_ADD,     4'd14, 8'h00, 4'd15, 1'b1, '{1'b0, 16'h0001}},
    '{nfasm_pkg::MODE_BEGIN,   4'd0,  8'h00, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'hFF, 4'd0,  1'b0, '0},
    // symbol with no transitions empties the set, and it stays empty
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h41, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h41, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_ADD,     4'd14, 8'h80, 4'd0,  1'b1, '{1'b0, 16'h0000}},
    '{nfasm_pkg::MODE_BEGIN,   4'd0,  8'h00, 4'd0,  1'b0, '0},
    // consuming the empty symbol itself
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h00, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'hFF, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h80, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_ADD,     4'd0,  8'h01, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h01, 4'd0,  1'b0, '0},
    '{nfasm_pkg::MODE_ADD,     4'd8,  8'hAA, 4'd7,  1'b0, '0},
    '{nfasm_pkg::MODE_ADD,     4'd7,  8'h55, 4'd8,  1'b0, '0},
    '{nfasm_pkg::MODE_CONSUME, 4'd0,  8'h55, 4'd0,  1'b0, '0},
    '{MODE_UNUSED,             4'd0,  8'h00, 4'd0,  1'b1, '{1'b0, 16'h0000}}
  };

  nfa_symbol_matcher u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_source_state (in_source_state),
    .in_symbol       (in_symbol),
    .in_target_state (in_target_state),
    .out_valid       (out_valid),
    .out_matched     (out_matched),
    .out_active_set  (out_active_set)
  );

  always #4 clk = ~clk;

  // Union of the rows of every state in the set, on one symbol.
  function automatic logic [REG_W-1:0] step_set(input logic [REG_W-1:0] set,
                                               input logic [SYMBOL_W-1:0] sym);
    logic [REG_W-1:0] nxt;
    nxt = '0;
    for (int s = 0; s < N_STATES; s++)
      if (set[s]) nxt |= trans_rows[s][sym];
    return nxt;
  endfunction

  // Grow the set along empty moves until it stops changing.
  function automatic logic [REG_W-1:0] eps_closure(input logic [REG_W-1:0] set);
    logic [REG_W-1:0] prev;
    do begin
      prev = set;
      set  = set | step_set(set, EMPTY_SYM);
    end while (set != prev);
    return set;
  endfunction

  // Advance the shadow automaton by one beat and return what the block owes.
  function automatic match_result_t advance_nfa(input logic [MODE_W-1:0] mode,
                                                input logic [STATE_IN_W-1:0] src,
                                                input logic [SYMBOL_W-1:0] sym,
                                                input logic [STATE_IN_W-1:0] dst);
    match_result_t res;
    case (mode)
      nfasm_pkg::MODE_ADD:
        trans_rows[src][sym] = trans_rows[src][sym] | (16'h0001 << dst);
      nfasm_pkg::MODE_BEGIN:
        active_now = eps_closure(start_reg);
      nfasm_pkg::MODE_CONSUME:
        active_now = eps_closure(step_set(eps_closure(active_now), sym));
      default: ;
    endcase
    res.matched    = |(active_now & accept_reg);
    res.active_set = active_now;
    return res;
  endfunction

  // Drive one beat; called and returning at a rising edge. Start is lowered
  // only when an idle gap is taken, so back-to-back beats keep it high.
  task automatic drive_beat(input logic [MODE_W-1:0] mode, input logic [STATE_IN_W-1:0] src,
                            input logic [SYMBOL_W-1:0] sym, input logic [STATE_IN_W-1:0] dst,
                            input int idle_pct, input logic typed, input match_result_t typed_res);
    match_result_t res;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start           <= 1'b1;
    in_mode         <= mode;
    in_source_state <= src;
    in_symbol       <= sym;
    in_target_state <= dst;
    // busy is stable mid-cycle; low here means the next edge takes the beat
    do @(negedge clk); while (busy !== 1'b0);
    res = advance_nfa(mode, src, sym, dst);
    pending_results.push_back(typed ? typed_res : res);
    @(posedge clk);
  endtask

  // Write both registers on back-to-back edges; called at a rising edge.
  task automatic set_config(input logic [REG_W-1:0] start_val,
                            input logic [REG_W-1:0] accept_val);
    cfg_we    <= 1'b1;
    cfg_index <= nfasm_pkg::CFG_START_SET;
    cfg_wdata <= start_val;
    @(posedge clk);
    cfg_index <= nfasm_pkg::CFG_ACCEPT_SET;
    cfg_wdata <= accept_val;
    @(posedge clk);
    cfg_we     <= 1'b0;
    start_reg  = start_val;
    accept_reg = accept_val;
  endtask

  // Drop start and hold until every owed result beat has come back.
  task automatic drain_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Mostly adds, begins and consumes over the phase's symbol band; a tenth
  // is noise: a random mode, the unused one included, and full-range symbols.
  task automatic run_phase(input int phase, input int idle_pct);
    int                    pick;
    logic [MODE_W-1:0]     mode;
    logic [STATE_IN_W-1:0] src;
    logic [SYMBOL_W-1:0]   sym;
    logic [STATE_IN_W-1:0] dst;
    repeat (PHASE_BEATS) begin
      pick = $urandom_range(99);
      src  = 4'($urandom_range(15));
      dst  = 4'($urandom_range(15));
      sym  = 8'(1 + phase * BAND_STRIDE + $urandom_range(BAND_WIDTH - 1));
      if (pick < 28) begin
        mode = nfasm_pkg::MODE_ADD;
        if ($urandom_range(99) < 3) sym = EMPTY_SYM;
      end else if (pick < 42) begin
        mode = nfasm_pkg::MODE_BEGIN;
      end else if (pick < 90) begin
        mode = nfasm_pkg::MODE_CONSUME;
        if ($urandom_range(99) < 3) sym = EMPTY_SYM;
      end else begin
        mode = 2'($urandom_range(3));
        sym  = 8'($urandom_range(255));
      end
      drive_beat(mode, src, sym, dst, idle_pct, 1'b0, '0);
    end
  endtask

  // Check each result beat against the oldest owed one, mid-cycle.
  always @(negedge clk) begin
    match_result_t want;
    if (out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing owed: active_set %h", out_active_set);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_matched !== want.matched) begin
          $error("matched: expected %0d, actual %0d", want.matched, out_matched);
          fail_count++;
        end
        if (out_active_set !== want.active_set) begin
          $error("active_set: expected %h, actual %h", want.active_set, out_active_set);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no beat moves on either side.
  always @(negedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int               idle_pct;
    logic [REG_W-1:0] start_val;
    logic [REG_W-1:0] accept_val;
    for (int s = 0; s < N_STATES; s++)
      for (int y = 0; y < N_SYMBOLS; y++)
        trans_rows[s][y] = '0;
    active_now = '0;
    start_reg  = '0;
    accept_reg = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    // the block takes register writes during its clearing sweep
    set_config(16'h0001, 16'h8000);

    foreach (directed_rows[i])
      drive_beat(directed_rows[i].mode, directed_rows[i].src, directed_rows[i].sym,
                 directed_rows[i].dst, 0, directed_rows[i].typed, directed_rows[i].result);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      // extremes first: all-start with nothing accepting, the reverse, then
      // everything (empty word accepted); later phases pick at random
      case (p)
        0: begin start_val = 16'hFFFF; accept_val = 16'h0000; end
        1: begin start_val = 16'h0000; accept_val = 16'hFFFF; end
        2: begin start_val = 16'hFFFF; accept_val = 16'hFFFF; end
        default: begin
          start_val  = $urandom_range(1) ? (16'h0001 << $urandom_range(15)) : 16'($urandom);
          accept_val = 16'($urandom);
        end
      endcase
      set_config(start_val, accept_val);
      // sender idling: none, heavy, none, light
      case (p % 4)
        1:       idle_pct = 72;
        3:       idle_pct = 33;
        default: idle_pct = 0;
      endcase
      run_phase(p, idle_pct);
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> nfa_symbol_matcher.f
+incdir+rtl
rtl/nfasm_pkg.sv
rtl/nfasm_row_ram.sv
rtl/nfa_symbol_matcher.sv
rtl/nfasm_checker.sv
sim/tb.sv
